>>> rtl/core/pse_pkg.sv
// Shared types and constants of the performance-state energy estimator.
// Item structs, table entry layout, codes and field widths.
// No dependencies.
package pse_pkg;

  localparam int FREQ_W     = 22;
  localparam int COST_W     = 32;
  localparam int UTIL_W     = 11;
  localparam int TOTAL_W    = 16;
  localparam int CAP_W      = 11;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 4;
  localparam int ENERGY_W   = 48;
  localparam int WANT_W     = FREQ_W + CAP_W;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int REG_SEL_W  = 2;

  localparam int MAX_STATES_DEF = 16;

  localparam logic [CAP_W-1:0]   CAP_RST   = CAP_W'(1024);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);

  // item operations
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_ESTIMATE = 1'b1;

  // register select (word address)
  localparam logic [REG_SEL_W-1:0] REG_CPU_CAPACITY = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_STATE_COUNT  = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_SKIP_INEFF   = 2'd2;

  typedef struct packed {
    logic                 op;
    logic [INDEX_W-1:0]   entry_index;
    logic [FREQ_W-1:0]    entry_frequency;
    logic [COST_W-1:0]    entry_cost;
    logic                 entry_inefficient;
    logic [UTIL_W-1:0]    peak_util;
    logic [TOTAL_W-1:0]   total_util;
    logic [UTIL_W-1:0]    allowed_capacity;
  } in_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0]  energy;
    logic [INDEX_W-1:0]   chosen_state;
  } out_item_t;

  typedef struct packed {
    logic                 inefficient;
    logic [COST_W-1:0]    cost;
    logic [FREQ_W-1:0]    frequency;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pse_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pse_pkg for the status struct.
module pse_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output logic [DVD_W-1:0]    quotient,
  output pse_pkg::div_stat_t  stat
);
  import pse_pkg::*;

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/core/perf_state_energy_estimator_unit.sv
// Top level of the performance-state energy estimator.
// Depends on pse_pkg, pse_ram (state table) and pse_div (shared divider).
//
// The block keeps a table of performance states (frequency, cost, inefficient
// mark) in one synchronous RAM. A load transfer writes one entry in the cycle
// it is accepted and yields no result; the block is ready again on the next
// cycle. An estimate transfer with zero total utilization yields energy 0 and
// state 0 without a table walk. Any other estimate reads the top state,
// forms frequency * clamped utilization, divides it by the capacity, walks the
// table from state 0 (per entry a RAM read, then a compare), multiplies
// the chosen cost by the total utilization and divides again. Both divisions
// go through one bit-serial divider of 48 steps, and the result goes to the
// output register once the second division is done and the register is free.
// One item is in flight at a time; the result sits in the output register,
// so the next item can be taken while the result waits.
// Configuration (APB, registers at 0x0 capacity, 0x4 state count, 0x8 skip
// inefficient) must only be written while the block is idle. Table entries
// that were never loaded read as unknown data.
module perf_state_energy_estimator_unit #(
  parameter int MAX_STATES = pse_pkg::MAX_STATES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pse_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pse_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pse_pkg::APB_AW-1:0]          paddr,
  input  logic [pse_pkg::APB_DW-1:0]          pwdata,
  output logic [pse_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import pse_pkg::*;

  localparam int SIDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int NW     = ($clog2(MAX_STATES + 1) > COUNT_W) ? $clog2(MAX_STATES + 1)
                                                            : COUNT_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TOP    = 4'd1;  // top state data back from RAM
  localparam logic [3:0] S_FSTART = 4'd2;  // launch frequency divide
  localparam logic [3:0] S_FWAIT  = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;  // table walk: issue read
  localparam logic [3:0] S_CMP    = 4'd5;  // table walk: compare
  localparam logic [3:0] S_ESTART = 4'd6;  // launch energy divide
  localparam logic [3:0] S_EWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;  // hand result to output register

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CAP_W-1:0]   cap_r;
  logic [COUNT_W-1:0] count_r;
  logic               skip_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RST;
      count_r <= COUNT_RST;
      skip_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CPU_CAPACITY: cap_r   <= pwdata[CAP_W-1:0];
        REG_STATE_COUNT:  count_r <= pwdata[COUNT_W-1:0];
        REG_SKIP_INEFF:   skip_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CPU_CAPACITY: prdata = APB_DW'(cap_r);
      REG_STATE_COUNT:  prdata = APB_DW'(count_r);
      REG_SKIP_INEFF:   prdata = APB_DW'(skip_r);
      default:          prdata = '0;
    endcase
  end

  // Effective capacity (zero acts as one) and state count (clamped 1..MAX).
  logic [CAP_W-1:0]  eff_cap;
  logic [NW-1:0]     cnt_ext;
  logic [NW-1:0]     eff_n;
  logic [NW-1:0]     last_n;
  logic [SIDX_W-1:0] last_idx;

  assign eff_cap = (cap_r == '0) ? CAP_W'(1) : cap_r;
  assign cnt_ext = NW'(count_r);

  always_comb begin
    if (cnt_ext == '0) begin
      eff_n = NW'(1);
    end else if (cnt_ext > NW'(MAX_STATES)) begin
      eff_n = NW'(MAX_STATES);
    end else begin
      eff_n = cnt_ext;
    end
  end

  assign last_n   = eff_n - NW'(1);
  assign last_idx = last_n[SIDX_W-1:0];

  // ---------------------------------------------------------------------
  // Handshake, load decode, utilization clamp
  // ---------------------------------------------------------------------
  logic [3:0] state_r, state_nxt;
  logic       in_xfer;
  logic       idx_ok;
  logic       tbl_we;
  logic [SIDX_W+INDEX_W-1:0] widx_ext;
  logic [SIDX_W-1:0]         tbl_waddr;
  entry_t                    tbl_wdata;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;

  assign idx_ok    = (32'(in_data.entry_index) < 32'(MAX_STATES));
  assign tbl_we    = in_xfer & (in_data.op == OP_LOAD) & idx_ok;
  assign widx_ext  = {SIDX_W'(0), in_data.entry_index};
  assign tbl_waddr = widx_ext[SIDX_W-1:0];

  assign tbl_wdata.inefficient = in_data.entry_inefficient;
  assign tbl_wdata.cost        = in_data.entry_cost;
  assign tbl_wdata.frequency   = in_data.entry_frequency;

  // peak + peak/4, clamped to the allowed capacity
  logic [UTIL_W:0]   util_raised;
  logic [UTIL_W-1:0] util_clamped;

  assign util_raised  = {1'b0, in_data.peak_util} + (UTIL_W + 1)'(in_data.peak_util >> 2);
  assign util_clamped = (util_raised > {1'b0, in_data.allowed_capacity})
                        ? in_data.allowed_capacity : util_raised[UTIL_W-1:0];

  // ---------------------------------------------------------------------
  // State table: one RAM word per performance state
  // ---------------------------------------------------------------------
  logic [SIDX_W-1:0]  scan_r, scan_nxt;
  logic [SIDX_W-1:0]  tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rword;
  entry_t             rd_entry;

  // The top state is read while idle so its data is there on the cycle
  // after the estimate transfer; a load never shares that edge with an
  // estimate, so no forwarding is needed.
  assign tbl_raddr = (state_r == S_RD) ? scan_r : last_idx;

  pse_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STATES),
    .AW    (SIDX_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rword)
  );

  assign rd_entry = entry_t'(tbl_rword);

  // ---------------------------------------------------------------------
  // Datapath: one multiply per step, registered, then the shared divider
  // ---------------------------------------------------------------------
  logic [UTIL_W-1:0]   util_r, util_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [ENERGY_W-1:0] prod_r, prod_nxt;
  logic [WANT_W-1:0]   want_r, want_nxt;
  logic [SIDX_W-1:0]   pick_r, pick_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [WANT_W-1:0]   f_mul;
  logic [ENERGY_W-1:0] e_mul;
  logic                hit;
  logic                last;

  assign f_mul = WANT_W'(rd_entry.frequency) * WANT_W'(util_r);
  assign e_mul = ENERGY_W'(rd_entry.cost) * ENERGY_W'(total_r);

  // first state fast enough, unless it is inefficient and skipping is on
  assign hit  = (WANT_W'(rd_entry.frequency) >= want_r) & ~(skip_r & rd_entry.inefficient);
  assign last = (scan_r == last_idx);

  logic                div_start;
  logic [ENERGY_W-1:0] div_quo;
  div_stat_t           div_stat;

  assign div_start = (state_r == S_FSTART) || (state_r == S_ESTART);

  pse_div #(
    .DVD_W (ENERGY_W),
    .DVS_W (CAP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (eff_cap),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;
  logic                 out_load;
  logic [SIDX_W+INDEX_W-1:0] pick_ext;

  assign out_load = (state_r == S_OUT) & (~out_valid_r | out_ready);
  assign pick_ext = {INDEX_W'(0), pick_r};

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    util_nxt   = util_r;
    total_nxt  = total_r;
    prod_nxt   = prod_r;
    want_nxt   = want_r;
    pick_nxt   = pick_r;
    energy_nxt = energy_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_data.op == OP_ESTIMATE)) begin
          util_nxt  = util_clamped;
          total_nxt = in_data.total_util;
          if (in_data.total_util == '0) begin
            energy_nxt = '0;
            pick_nxt   = '0;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_TOP;
          end
        end
      end
      S_TOP: begin
        prod_nxt  = ENERGY_W'(f_mul);
        state_nxt = S_FSTART;
      end
      S_FSTART: begin
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_stat.done) begin
          want_nxt  = div_quo[WANT_W-1:0];
          scan_nxt  = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit || last) begin
          pick_nxt  = scan_r;
          prod_nxt  = e_mul;
          state_nxt = S_ESTART;
        end else begin
          scan_nxt  = scan_r + SIDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_ESTART: begin
        state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        if (div_stat.done) begin
          energy_nxt = div_quo;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    util_r   <= util_nxt;
    total_r  <= total_nxt;
    prod_r   <= prod_nxt;
    want_r   <= want_nxt;
    pick_r   <= pick_nxt;
    energy_r <= energy_nxt;
    if (out_load) begin
      out_data_r.energy       <= energy_r;
      out_data_r.chosen_state <= pick_ext[INDEX_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // divider is never relaunched while a division is running
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a quotient only arrives while the sequencer waits for one
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> ((state_r == S_FWAIT) || (state_r == S_EWAIT)))
    else $error("divider result with no waiting step");

  // the table walk never runs past the last valid state
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (scan_r <= last_idx))
    else $error("table walk beyond last state");

  // a result is handed over only when the output register can take it
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

>>> verif/pse_energy_checker.sv
// Checker for the performance-state energy estimator: watches the item, result
// and register ports, predicts every estimate result and compares it.
// Depends on pse_pkg only.
module pse_energy_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  pse_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  pse_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pse_pkg::APB_AW-1:0]   paddr,
  input  logic [pse_pkg::APB_DW-1:0]   pwdata,
  input  logic                         pready,
  output int                           mismatches,
  output int                           outstanding,
  output int                           compared
);
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam int DEPTH = MAX_STATES_DEF;

  // shadow of the state table and of the registers
  logic [FREQ_W-1:0]  tbl_freq [DEPTH];
  logic [COST_W-1:0]  tbl_cost [DEPTH];
  logic               tbl_slow [DEPTH];
  logic [CAP_W-1:0]   cpu_cap;
  logic [COUNT_W-1:0] state_cnt;
  logic               skip_slow;

  out_item_t energy_due [$];

  function automatic out_item_t estimate_energy(in_item_t it);
    bit [63:0] cap;
    bit [63:0] n;
    bit [63:0] util;
    bit [63:0] want;
    bit [63:0] pick;
    bit [63:0] energy;
    bit [63:0] i;
    bit        found;
    out_item_t r;
    r = '0;
    if (it.total_util == '0) return r;
    cap = (cpu_cap == '0) ? 64'd1 : 64'(cpu_cap);
    if (state_cnt == '0) n = 64'd1;
    else if (state_cnt > DEPTH) n = 64'(DEPTH);
    else n = 64'(state_cnt);
    util = 64'(it.peak_util);
    util = util + (util >> 2);
    if (util > 64'(it.allowed_capacity)) util = 64'(it.allowed_capacity);
    want = 64'(tbl_freq[n-1]) * util / cap;
    // first state fast enough; falls back to the top one
    pick  = n - 1;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && 64'(tbl_freq[i]) >= want && !(skip_slow && tbl_slow[i])) begin
        pick  = i;
        found = 1'b1;
      end
    end
    energy = 64'(tbl_cost[pick]) * 64'(it.total_util) / cap;
    r.energy       = energy[ENERGY_W-1:0];
    r.chosen_state = pick[INDEX_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      cpu_cap     = CAP_RST;
      state_cnt   = COUNT_RST;
      skip_slow   = 1'b0;
      energy_due.delete();
      mismatches  = 0;
      compared    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_CPU_CAPACITY: cpu_cap   = pwdata[CAP_W-1:0];
          REG_STATE_COUNT:  state_cnt = pwdata[COUNT_W-1:0];
          REG_SKIP_INEFF:   skip_slow = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (energy_due.size() == 0) begin
          $error("unexpected result: energy %0d, chosen_state %0d",
                 out_data.energy, out_data.chosen_state);
          mismatches++;
        end else begin
          due = energy_due.pop_front();
          compared++;
          if (out_data.energy !== due.energy) begin
            $error("energy mismatch: expected %0d, actual %0d",
                   due.energy, out_data.energy);
            mismatches++;
          end
          if (out_data.chosen_state !== due.chosen_state) begin
            $error("chosen_state mismatch: expected %0d, actual %0d",
                   due.chosen_state, out_data.chosen_state);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_LOAD) begin
          tbl_freq[in_data.entry_index] = in_data.entry_frequency;
          tbl_cost[in_data.entry_index] = in_data.entry_cost;
          tbl_slow[in_data.entry_index] = in_data.entry_inefficient;
        end else begin
          energy_due.push_back(estimate_energy(in_data));
        end
      end
    end
    outstanding = energy_due.size();
  end

endmodule

>>> verif/perf_state_energy_estimator_unit_test.sv
// Testbench top of the performance-state energy estimator: reset, register
// settings, directed and random item streams, result back-pressure, verdict.
// Depends on pse_pkg, perf_state_energy_estimator_unit and pse_energy_checker.
module perf_state_energy_estimator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int ITEM_TOTAL  = 1350;
  localparam int SETTINGS_N  = 12;
  localparam int PHASE_ITEMS = ITEM_TOTAL / SETTINGS_N;
  // settle time before a register write
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 600;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [APB_AW-1:0]   paddr     = '0;
  logic [APB_DW-1:0]   pwdata    = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int mismatches;
  int outstanding;
  int compared;

  int   cycle_count    = 0;
  int   burst_left     = 0;
  int   loads_sent     = 0;
  int   estimates_sent = 0;
  int   settings_run   = 0;
  logic hold_req       = 1'b0;
  bit   hold_done      = 1'b0;

  perf_state_energy_estimator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pse_energy_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  // 20 ns clock, first rising edge at 10 ns
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Item builders. Fields that an operation ignores carry random junk so that
  // every input bit toggles on both kinds of transfer.
  // ---------------------------------------------------------------------------
  function automatic in_item_t random_item();
    in_item_t it;
    it.op                = 1'($urandom_range(0, 1));
    it.entry_index       = INDEX_W'($urandom_range(0, 15));
    it.entry_frequency   = FREQ_W'($urandom);
    it.entry_cost        = $urandom;
    it.entry_inefficient = 1'($urandom_range(0, 1));
    it.peak_util         = UTIL_W'($urandom_range(0, 1024));
    it.total_util        = TOTAL_W'($urandom);
    it.allowed_capacity  = UTIL_W'($urandom_range(0, 1024));
    return it;
  endfunction

  function automatic in_item_t make_load(int idx, logic [FREQ_W-1:0] freq,
                                         logic [COST_W-1:0] cost, logic slow);
    in_item_t it;
    it                   = random_item();
    it.op                = OP_LOAD;
    it.entry_index       = INDEX_W'(idx);
    it.entry_frequency   = freq;
    it.entry_cost        = cost;
    it.entry_inefficient = slow;
    return it;
  endfunction

  function automatic in_item_t make_estimate(int peak, int total, int allowed);
    in_item_t it;
    it                  = random_item();
    it.op               = OP_ESTIMATE;
    it.peak_util        = UTIL_W'(peak);
    it.total_util       = TOTAL_W'(total);
    it.allowed_capacity = UTIL_W'(allowed);
    return it;
  endfunction

  // utilization with the range ends weighted up
  function automatic int pick_util();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1024;
      default: return $urandom_range(0, 1024);
    endcase
  endfunction

  function automatic int pick_total();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      2, 3, 4: return $urandom_range(1, 2048);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Bursts of random length, random gaps between bursts; a gap of
  // zero merges two bursts into one long back-to-back stretch.
  // ---------------------------------------------------------------------------
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    // valid and ready read here are the values the edge sampled
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.op == OP_LOAD) loads_sent++;
    else estimates_sent++;
  endtask

  // stop offering and wait until every due result has been taken, then let
  // the block settle; outstanding is read at the falling edge, away from the
  // checker's update
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then an idle phase before the next transfer
  task automatic cfg_write(input logic [REG_SEL_W-1:0] which,
                           input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int cap, input int count, input int skip);
    drain(SETTLE);
    cfg_write(REG_CPU_CAPACITY, APB_DW'(cap));
    cfg_write(REG_STATE_COUNT, APB_DW'(count));
    cfg_write(REG_SKIP_INEFF, APB_DW'(skip));
    settings_run++;
  endtask

  // ascending frequency table with random costs and a few inefficient states;
  // this is the shape the search is built for
  task automatic load_ladder();
    longint base;
    longint step;
    longint f;
    int     i;
    base = $urandom_range(0, 200000);
    step = $urandom_range(1, 280000);
    for (i = 0; i < MAX_STATES_DEF; i++) begin
      f = base + i * step;
      if (f > longint'(FREQ_MAX)) f = longint'(FREQ_MAX);
      send(make_load(i, FREQ_W'(f), $urandom, $urandom_range(0, 3) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The stall pattern switches between random modes. Once
  // asked, it holds off for a long stretch so the block backs up into its
  // input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int mode;
    int mode_left;
    int held;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int k;
    int p;
    int first;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: full table, skipping on. State 0 and every fourth state
    // are inefficient, the top state too, so a request above everything
    // skips its way to the fallback.
    cfg_write(REG_CPU_CAPACITY, APB_DW'(1024));
    cfg_write(REG_STATE_COUNT, APB_DW'(MAX_STATES_DEF));
    cfg_write(REG_SKIP_INEFF, APB_DW'(1));
    settings_run++;
    for (i = 0; i < MAX_STATES_DEF; i++) begin
      send(make_load(i,
                     (i == MAX_STATES_DEF - 1) ? FREQ_MAX : FREQ_W'(i * 262144),
                     (i == MAX_STATES_DEF - 1) ? COST_MAX :
                     (i == 0) ? '0 : COST_W'($urandom),
                     (i == 0) || (i % 4 == 3)));
    end
    send(make_estimate(500, 0, 1024));      // zero total: energy 0, state 0
    send(make_estimate(0, 1, 1024));        // zero request, state 0 skipped
    send(make_estimate(1024, 65535, 1024)); // top request, biggest energy
    send(make_estimate(1024, 1000, 0));     // allowed capacity zero
    send(make_estimate(800, 300, 900));     // quarter headroom clamped
    send(make_estimate(400, 777, 1024));    // lands mid table
    send(make_estimate(1, 65535, 1));
    send(make_estimate(1023, 32768, 1023));
    send(make_estimate(600, 65535, 1024));

    // Random part: one batch per register setting. The first settings walk
    // the register extremes (zero capacity, capacity 1 and all ones, count
    // zero and above the table size); the rest are random.
    for (p = 0; p < SETTINGS_N; p++) begin
      case (p)
        0:       apply_setting(1024, 16, 0);
        1:       apply_setting(1, 16, 1);
        2:       apply_setting(0, 8, 0);
        3:       apply_setting(2047, 0, 1);
        4:       apply_setting(512, 17, 0);
        5:       apply_setting(700, 31, 1);
        6:       apply_setting(1024, 1, 0);
        7:       apply_setting(3, 4, 1);
        default: apply_setting($urandom_range(1, 1024), $urandom_range(1, 16),
                               $urandom_range(0, 1));
      endcase
      // long result hold-off during the second batch
      if (p == 1) hold_req <= 1'b1;
      first = 0;
      if ($urandom_range(0, 1) == 1) begin
        load_ladder();
        first = MAX_STATES_DEF;
      end
      for (k = first; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 4) == 0)
          send(make_load($urandom_range(0, 15), FREQ_W'($urandom), $urandom,
                         1'($urandom_range(0, 1))));
        else
          send(make_estimate(pick_util(), pick_total(), pick_util()));
      end
    end

    drain(SETTLE);

    $display("covered %0d loads and %0d estimates over %0d register settings",
             loads_sent, estimates_sent, settings_run);
    $display("%0d results compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
